FILE: hw/rtl/swhc_pkg.sv
// shared constants, types and state codes for the sliding window hit counter
`timescale 1ns / 1ps
package swhc_pkg;

	localparam int WINDOW = 300;
	localparam int TS_W   = 31;
	localparam int CNT_W  = 32;
	localparam int TOT_W  = 41;
	localparam int IDX_W  = $clog2(WINDOW);

	// reciprocal of WINDOW scaled by 2^RECIP_SH, rounded up
	localparam int RECIP_W  = 32;
	localparam int RECIP_SH = TS_W + IDX_W;
	localparam int QUO_W    = TS_W + RECIP_W - RECIP_SH;
	localparam logic [RECIP_W-1:0] RECIP_M =
		RECIP_W'(((64'd1 << RECIP_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

	localparam logic OP_HIT   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic [TS_W-1:0]  stamp;
		logic [CNT_W-1:0] count;
	} entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_WRITE,
		ST_SCAN,
		ST_LAST
	} state_t;

endpackage

FILE: hw/rtl/sliding_window_hit_counter.sv
// sliding window hit counter: top level with bucket memory and sequencer
//
// Counts hits over a rolling window of WINDOW (300) time units in a table of
// WINDOW buckets held in one single-port-write, registered-read memory. After
// reset the block clears the table, one bucket a cycle, with busy high. A
// request is taken when start is high and busy is low. A hit request
// multiplies the timestamp by the reciprocal of WINDOW at the accepting edge,
// then registers the remainder, reads the bucket and writes it back. In a
// query request the bucket memory is read one entry a cycle into a single
// saturating accumulator; at the end total_hits is shown for one cycle with
// done high, and the receiver must take it then. Hits give no result.
`timescale 1ns / 1ps
module sliding_window_hit_counter
	import swhc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             operation,
	input  logic [TS_W-1:0]  timestamp,
	output logic             done,
	output logic [TOT_W-1:0] total_hits
);

	state_t            state_q;
	state_t            state_nxt;
	logic [IDX_W-1:0]  addr_q;
	logic [IDX_W-1:0]  slot_q;
	logic [TS_W-1:0]   ts_q;
	logic [TOT_W-1:0]  sum_q;
	logic [TOT_W-1:0]  total_q;
	logic              done_q;
	logic              rd_vld_s1;
	entry_t            rd_data_s1;
	entry_t            mem [WINDOW];

	logic              rem_start;
	logic              rem_done;
	logic [IDX_W-1:0]  rem_val;

	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_data;

	logic              addr_last;
	logic [TS_W:0]     diff;
	logic              in_window;
	logic [TOT_W:0]    add;
	logic [TOT_W-1:0]  sum_nxt;

	swhc_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start),
		.dividend  (timestamp),
		.done      (rem_done),
		.remainder (rem_val)
	);

	assign addr_last = (addr_q == IDX_W'(WINDOW - 1));
	assign busy      = (state_q != ST_IDLE);
	assign rem_start = (state_q == ST_IDLE) && start && (operation == OP_HIT);

	// window test on the signed difference, then saturating accumulate
	always_comb begin
		diff      = {1'b0, ts_q} - {1'b0, rd_data_s1.stamp};
		in_window = ($signed(diff) < $signed((TS_W + 1)'(WINDOW)));
		add       = {1'b0, sum_q} + (TOT_W + 1)'(in_window ? rd_data_s1.count : '0);
		sum_nxt   = add[TOT_W] ? '1 : add[TOT_W-1:0];
	end

	// bucket update and memory port selection
	always_comb begin
		rd_addr = (state_q == ST_SCAN) ? addr_q : rem_val;
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = '0;
		if (state_q == ST_CLEAR) begin
			wr_en = 1'b1;
		end else if (state_q == ST_WRITE) begin
			wr_en         = 1'b1;
			wr_addr       = slot_q;
			wr_data.stamp = ts_q;
			if (rd_data_s1.stamp != ts_q) begin
				wr_data.count = CNT_W'(1);
			end else if (rd_data_s1.count != '1) begin
				wr_data.count = rd_data_s1.count + CNT_W'(1);
			end else begin
				wr_data.count = rd_data_s1.count;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (addr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_nxt = (operation == OP_HIT) ? ST_MOD : ST_SCAN;
				end
			end
			ST_MOD: begin
				if (rem_done) begin
					state_nxt = ST_WRITE;
				end
			end
			ST_WRITE: state_nxt = ST_IDLE;
			ST_SCAN: begin
				if (addr_last) begin
					state_nxt = ST_LAST;
				end
			end
			ST_LAST:  state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
			sum_q     <= '0;
		end else begin
			state_q   <= state_nxt;
			rd_vld_s1 <= (state_q == ST_SCAN);
			done_q    <= (state_q == ST_LAST);
			if (state_q == ST_CLEAR || state_q == ST_SCAN) begin
				addr_q <= addr_last ? '0 : addr_q + IDX_W'(1);
			end
			if (state_q == ST_IDLE) begin
				sum_q <= '0;
			end else if (rd_vld_s1) begin
				sum_q <= sum_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			ts_q <= timestamp;
		end
		if (state_q == ST_MOD && rem_done) begin
			slot_q <= rem_val;
		end
		if (state_q == ST_LAST) begin
			total_q <= sum_nxt;
		end
	end

	// bucket memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	assign done       = done_q;
	assign total_hits = total_q;

endmodule

FILE: hw/rtl/swhc_rem.sv
// remainder of a timestamp by the window length through reciprocal multiplication
`timescale 1ns / 1ps
module swhc_rem
	import swhc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [TS_W-1:0]  dividend,
	output logic             done,
	output logic [IDX_W-1:0] remainder
);

	logic                     vld_s1;
	logic                     done_q;
	logic [TS_W-1:0]          dvd_s1;
	logic [TS_W+RECIP_W-1:0]  prod_s1;
	logic [IDX_W-1:0]         rem_q;
	logic [QUO_W-1:0]         quo;
	logic [TS_W-1:0]          back;
	logic [TS_W-1:0]          rem_full;

	// quotient from the scaled product, then subtract quotient times window
	always_comb begin
		quo      = prod_s1[TS_W+RECIP_W-1:RECIP_SH];
		back     = TS_W'(quo) * TS_W'(WINDOW);
		rem_full = dvd_s1 - back;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_s1  <= dividend;
			prod_s1 <= (TS_W + RECIP_W)'(dividend) * (TS_W + RECIP_W)'(RECIP_M);
		end
		if (vld_s1) begin
			rem_q <= rem_full[IDX_W-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

FILE: tb/sv/hit_window_check_pkg.sv
// scoreboard class predicting window totals for the sliding window hit counter testbench
`timescale 1ns / 1ps
package hit_window_check_pkg;
	import swhc_pkg::*;

	localparam longint unsigned TOTAL_CEIL = (64'd1 << TOT_W) - 64'd1;
	localparam logic [CNT_W-1:0] COUNT_CEIL = {CNT_W{1'b1}};

	class hit_window_scoreboard;
		logic [TS_W-1:0]  stamp_tab [WINDOW];
		logic [CNT_W-1:0] count_tab [WINDOW];
		logic [TOT_W-1:0] pending_totals [$];
		int unsigned      fault_count;

		function new();
			foreach (stamp_tab[i]) begin
				stamp_tab[i] = '0;
				count_tab[i] = '0;
			end
			fault_count = 0;
		endfunction

		function void note_request(logic op, logic [TS_W-1:0] ts);
			int              slot;
			longint unsigned sum;
			if (op == OP_HIT) begin
				slot = int'(ts) % WINDOW;
				if (stamp_tab[slot] != ts) begin
					stamp_tab[slot] = ts;
					count_tab[slot] = CNT_W'(1);
				end else if (count_tab[slot] != COUNT_CEIL) begin
					count_tab[slot] = count_tab[slot] + CNT_W'(1);
				end
			end else begin
				sum = 0;
				for (int k = 0; k < WINDOW; k++) begin
					// signed difference, so stamps ahead of the query time still count
					if (longint'(ts) - longint'(stamp_tab[k]) < longint'(WINDOW)) begin
						sum = sum + longint'(count_tab[k]);
						if (sum > TOTAL_CEIL)
							sum = TOTAL_CEIL;
					end
				end
				pending_totals.push_back(sum[TOT_W-1:0]);
			end
		endfunction

		function void check_total(logic [TOT_W-1:0] actual);
			logic [TOT_W-1:0] expected;
			if (pending_totals.size() == 0) begin
				$display("%0t: total_hits expected none, actual %0d", $time, actual);
				fault_count++;
			end else begin
				expected = pending_totals.pop_front();
				if (actual !== expected) begin
					$display("%0t: total_hits expected %0d, actual %0d",
						$time, expected, actual);
					fault_count++;
				end
			end
		endfunction
	endclass

endpackage

FILE: tb/sv/tb_top.sv
// top-level testbench for the sliding window hit counter with directed and random requests
`timescale 1ns / 1ps
module tb_top;
	import swhc_pkg::*;
	import hit_window_check_pkg::*;

	localparam int     RANDOM_ITEMS = 2000;
	localparam longint STAMP_TOP    = (64'd1 << TS_W) - 64'd1;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	logic             operation = OP_HIT;
	logic [TS_W-1:0]  timestamp = '0;
	logic             busy;
	logic             done;
	logic [TOT_W-1:0] total_hits;

	hit_window_scoreboard sb = new();

	sliding_window_hit_counter DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.timestamp  (timestamp),
		.done       (done),
		.total_hits (total_hits)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_total(total_hits);
			if (start && !busy)
				sb.note_request(operation, timestamp);
		end
	end

	// called at a falling edge, returns at the falling edge after the request is taken
	task automatic send_request(input logic op, input logic [TS_W-1:0] ts);
		operation <= op;
		timestamp <= ts;
		start     <= 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic pause(input int cycles);
		logic [31:0] junk;
		junk = $urandom;
		start     <= 1'b0;
		operation <= junk[31];
		timestamp <= junk[TS_W-1:0];
		repeat (cycles) @(negedge clk);
	endtask

	function automatic logic [TS_W-1:0] random_stamp();
		logic [31:0] r;
		r = $urandom;
		return r[TS_W-1:0];
	endfunction

	initial begin
		longint           now;
		longint           probe;
		logic             op;
		logic [TS_W-1:0]  ts;
		int               sent;
		int               burst;
		int               roll;
		int               gap;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// buckets never hit, repeated stamp, bucket reuse and the window edge
		send_request(OP_QUERY, TS_W'(0));
		send_request(OP_HIT, TS_W'(0));
		send_request(OP_HIT, TS_W'(0));
		send_request(OP_HIT, TS_W'(0));
		send_request(OP_QUERY, TS_W'(0));
		send_request(OP_HIT, TS_W'(WINDOW - 1));
		send_request(OP_HIT, TS_W'(WINDOW));
		send_request(OP_QUERY, TS_W'(WINDOW));
		pause(3);
		send_request(OP_QUERY, TS_W'(2 * WINDOW - 2));
		send_request(OP_QUERY, TS_W'(2 * WINDOW - 1));
		send_request(OP_QUERY, TS_W'(2 * WINDOW));
		// time going backward
		send_request(OP_HIT, TS_W'(100));
		send_request(OP_QUERY, TS_W'(50));
		send_request(OP_HIT, TS_W'(0));
		send_request(OP_QUERY, TS_W'(0));
		// extremes of the timestamp
		send_request(OP_HIT, TS_W'(STAMP_TOP));
		send_request(OP_HIT, TS_W'(STAMP_TOP));
		send_request(OP_QUERY, TS_W'(STAMP_TOP));
		send_request(OP_HIT, TS_W'(31'h2AAA_AAAA));
		send_request(OP_QUERY, TS_W'(31'h5555_5555));
		send_request(OP_QUERY, TS_W'(0));
		pause(1);

		now  = longint'($urandom_range(0, 5000));
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				roll = $urandom_range(0, 99);
				if (roll < 5) begin
					ts = random_stamp();
					if ($urandom_range(0, 1))
						now = longint'(ts);
				end else if (roll < 10) begin
					probe = now - longint'($urandom_range(1, 400));
					ts = (probe < 0) ? TS_W'(0) : TS_W'(probe);
				end else begin
					roll = $urandom_range(0, 99);
					if (roll < 45)
						now = now;
					else if (roll < 80)
						now = now + longint'($urandom_range(1, 4));
					else if (roll < 92)
						now = now + longint'($urandom_range(25, 120));
					else
						now = now + longint'($urandom_range(WINDOW - 1, WINDOW + 1));
					if (now > STAMP_TOP)
						now = longint'($urandom_range(0, 1000));
					ts = TS_W'(now);
				end
				op = ($urandom_range(0, 99) < 28) ? OP_QUERY : OP_HIT;
				if (op == OP_QUERY && $urandom_range(0, 3) == 0) begin
					probe = now + longint'($urandom_range(WINDOW - 2, WINDOW + 2));
					if (probe <= STAMP_TOP)
						ts = TS_W'(probe);
				end
				send_request(op, ts);
				sent++;
			end
			roll = $urandom_range(0, 99);
			if (roll < 25)
				gap = 0;
			else if (roll < 85)
				gap = $urandom_range(1, 6);
			else
				gap = $urandom_range(7, 320);
			if (gap > 0)
				pause(gap);
		end
		pause(1);

		while (sb.pending_totals.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);

		if (sb.fault_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
